// ===== sv/acm_pkg.sv =====
// Shared types, opcodes and result codes of the accumulator machine.
package acm_pkg;

    localparam int MEM_DEPTH_DEF = 256;
    localparam logic [7:0] START_ADDR_RESET = 8'd80;

    localparam logic [7:0] OPC_HALT = 8'h00;
    localparam logic [7:0] OPC_ADD  = 8'h40;
    localparam logic [7:0] OPC_SUB  = 8'h41;
    localparam logic [7:0] OPC_LDI  = 8'h48;
    localparam logic [7:0] OPC_AND  = 8'h49;
    localparam logic [7:0] OPC_OR   = 8'h4A;
    localparam logic [7:0] OPC_XOR  = 8'h4B;
    localparam logic [7:0] OPC_NOT  = 8'h4C;
    localparam logic [7:0] OPC_SHL  = 8'h4D;
    localparam logic [7:0] OPC_SHR  = 8'h4E;
    localparam logic [7:0] OPC_INC  = 8'h4F;
    localparam logic [7:0] OPC_DEC  = 8'h50;
    localparam logic [7:0] OPC_DBL  = 8'h51;
    localparam logic [7:0] OPC_HLV  = 8'h52;
    localparam logic [7:0] OPC_NOP  = 8'h53;
    localparam logic [7:0] OPC_SET  = 8'h54;
    localparam logic [7:0] BYTE_ONES = 8'hFF;

    typedef enum logic [2:0] {
        STAT_EXEC    = 3'd0,
        STAT_HALT    = 3'd1,
        STAT_UNKNOWN = 3'd2,
        STAT_PASTEND = 3'd3,
        STAT_LOADED  = 3'd4,
        STAT_BADLOAD = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        RUN_RUNNING = 2'd0,
        RUN_HALTED  = 2'd1,
        RUN_UNKNOWN = 2'd2,
        RUN_PASTEND = 2'd3
    } run_t;

    // Opcode decode flags from the ALU to the sequencer
    typedef struct packed {
        logic halt;
        logic needs_imm;
        logic known;
    } acm_dec_t;

endpackage

// ===== sv/acm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module acm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== sv/acm_alu.sv =====
// Opcode decoder and accumulator arithmetic.
module acm_alu (
    input  logic [7:0]        opcode,
    input  logic [7:0]        acc,
    input  logic [7:0]        imm,
    output acm_pkg::acm_dec_t dec,
    output logic [7:0]        result
);
    import acm_pkg::*;

    always_comb
    begin
        dec    = '0;
        result = acc;
        unique case (opcode)
            OPC_HALT:
            begin
                dec.halt  = 1'b1;
                dec.known = 1'b1;
            end
            OPC_ADD: begin dec.needs_imm = 1'b1; dec.known = 1'b1; result = acc + imm; end
            OPC_SUB: begin dec.needs_imm = 1'b1; dec.known = 1'b1; result = acc - imm; end
            OPC_LDI: begin dec.needs_imm = 1'b1; dec.known = 1'b1; result = imm;       end
            OPC_AND: begin dec.needs_imm = 1'b1; dec.known = 1'b1; result = acc & imm; end
            OPC_OR:  begin dec.needs_imm = 1'b1; dec.known = 1'b1; result = acc | imm; end
            OPC_XOR: begin dec.needs_imm = 1'b1; dec.known = 1'b1; result = acc ^ imm; end
            OPC_NOT: begin dec.known = 1'b1; result = ~acc;                 end
            OPC_SHL: begin dec.known = 1'b1; result = {acc[6:0], 1'b0};     end
            OPC_SHR: begin dec.known = 1'b1; result = {1'b0, acc[7:1]};     end
            OPC_INC: begin dec.known = 1'b1; result = acc + 8'd1;           end
            OPC_DEC: begin dec.known = 1'b1; result = acc - 8'd1;           end
            OPC_DBL: begin dec.known = 1'b1; result = {acc[6:0], 1'b0};     end
            OPC_HLV: begin dec.known = 1'b1; result = {1'b0, acc[7:1]};     end
            OPC_NOP: begin dec.known = 1'b1; result = acc & BYTE_ONES;      end
            OPC_SET: begin dec.known = 1'b1; result = acc | BYTE_ONES;      end
            default:
            begin
                dec.known = 1'b0;
            end
        endcase
    end
endmodule

// ===== sv/accumulator_machine_step.sv =====
// Top level of the accumulator machine: sequencer, program store and registers.
//
//  channel   handshake                  payload
//  request   start / busy               op, address, first_byte, second_byte
//  result    done (one-cycle strobe)    status, program_counter, accumulator
//  config    cfg_wr_en                  cfg_wr_data (start address, loads pc)
//
// A load writes its two bytes through the one store write port, one byte per cycle;
// a step reads the opcode, and then any immediate byte, through the one read port.
// A refused load or a step on a stopped machine is answered from the idle state alone.
// done rises the cycle after the last cycle of an item; busy is low again then.
// Reset clears the store at once through per-byte valid bits; no clearing pass.
// The receiver cannot stall; results are never held.
module accumulator_machine_step #(
    parameter int MEM_DEPTH = acm_pkg::MEM_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       op,
    input  logic [7:0] address,
    input  logic [7:0] first_byte,
    input  logic [7:0] second_byte,
    output logic       done,
    output logic [2:0] status,
    output logic [8:0] program_counter,
    output logic [7:0] accumulator,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data
);
    import acm_pkg::*;

    localparam int AW = $clog2(MEM_DEPTH);
    localparam logic [8:0] DEPTH_9 = 9'(MEM_DEPTH);
    localparam logic [8:0] LAST_9  = 9'(MEM_DEPTH - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD2,
        S_OP_WAIT,
        S_IMM_WAIT
    } state_t;

    state_t           state_reg;
    logic             done_reg;
    status_t          status_reg;
    logic [8:0]       pc_reg;
    logic [7:0]       acc_reg;
    run_t             run_state_reg;
    logic [7:0]       opc_reg;
    logic [AW-1:0]    load_addr_reg;
    logic [7:0]       load_byte_reg;
    logic [MEM_DEPTH-1:0] valid_reg;
    logic             rd_valid_reg;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [7:0]       mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic [7:0]       ram_q;
    logic [7:0]       rd_byte;
    logic [7:0]       alu_opcode;
    logic [7:0]       alu_result;
    acm_dec_t         dec;
    logic [7:0]       addr_inc;
    logic             load_ok;
    logic             pc_past;

    assign addr_inc  = address + 8'd1;
    assign load_ok   = {1'b0, address} < LAST_9;
    assign pc_past   = pc_reg >= DEPTH_9;
    assign mem_raddr = pc_reg[AW-1:0];
    // A never-written byte reads as zero
    assign rd_byte   = rd_valid_reg ? ram_q : 8'd0;
    assign alu_opcode = (state_reg == S_OP_WAIT) ? rd_byte : opc_reg;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = address[AW-1:0];
        mem_wdata = first_byte;
        if (state_reg == S_LOAD2)
        begin
            mem_we    = 1'b1;
            mem_waddr = load_addr_reg;
            mem_wdata = load_byte_reg;
        end
        else if (state_reg == S_IDLE && start && !op && load_ok)
        begin
            mem_we = 1'b1;
        end
    end

    acm_ram #(
        .WIDTH (8),
        .DEPTH (MEM_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (ram_q)
    );

    acm_alu u_alu (
        .opcode (alu_opcode),
        .acc    (acc_reg),
        .imm    (rd_byte),
        .dec    (dec),
        .result (alu_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                valid_reg[mem_waddr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            done_reg      <= 1'b0;
            status_reg    <= STAT_EXEC;
            pc_reg        <= {1'b0, START_ADDR_RESET};
            acc_reg       <= 8'd0;
            run_state_reg <= RUN_RUNNING;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cfg_wr_en)
                    begin
                        pc_reg <= {1'b0, cfg_wr_data};
                    end
                    if (start)
                    begin
                        if (!op)
                        begin
                            if (load_ok)
                            begin
                                load_addr_reg <= addr_inc[AW-1:0];
                                load_byte_reg <= second_byte;
                                state_reg     <= S_LOAD2;
                            end
                            else
                            begin
                                done_reg   <= 1'b1;
                                status_reg <= STAT_BADLOAD;
                            end
                        end
                        else
                        begin
                            unique case (run_state_reg)
                                RUN_RUNNING:
                                begin
                                    if (pc_past)
                                    begin
                                        run_state_reg <= RUN_PASTEND;
                                        done_reg      <= 1'b1;
                                        status_reg    <= STAT_PASTEND;
                                    end
                                    else
                                    begin
                                        // opcode read issued at pc this cycle
                                        pc_reg    <= pc_reg + 9'd1;
                                        state_reg <= S_OP_WAIT;
                                    end
                                end
                                RUN_HALTED:
                                begin
                                    done_reg   <= 1'b1;
                                    status_reg <= STAT_HALT;
                                end
                                RUN_UNKNOWN:
                                begin
                                    done_reg   <= 1'b1;
                                    status_reg <= STAT_UNKNOWN;
                                end
                                RUN_PASTEND:
                                begin
                                    done_reg   <= 1'b1;
                                    status_reg <= STAT_PASTEND;
                                end
                                default:
                                begin
                                    done_reg   <= 1'b1;
                                    status_reg <= STAT_PASTEND;
                                end
                            endcase
                        end
                    end
                end
                S_LOAD2:
                begin
                    done_reg   <= 1'b1;
                    status_reg <= STAT_LOADED;
                    state_reg  <= S_IDLE;
                end
                S_OP_WAIT:
                begin
                    opc_reg <= rd_byte;
                    priority if (dec.halt)
                    begin
                        run_state_reg <= RUN_HALTED;
                        done_reg      <= 1'b1;
                        status_reg    <= STAT_HALT;
                        state_reg     <= S_IDLE;
                    end
                    else if (dec.needs_imm)
                    begin
                        if (pc_past)
                        begin
                            run_state_reg <= RUN_PASTEND;
                            done_reg      <= 1'b1;
                            status_reg    <= STAT_PASTEND;
                            state_reg     <= S_IDLE;
                        end
                        else
                        begin
                            // immediate read issued at the advanced pc
                            pc_reg    <= pc_reg + 9'd1;
                            state_reg <= S_IMM_WAIT;
                        end
                    end
                    else if (dec.known)
                    begin
                        acc_reg    <= alu_result;
                        done_reg   <= 1'b1;
                        status_reg <= STAT_EXEC;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        run_state_reg <= RUN_UNKNOWN;
                        done_reg      <= 1'b1;
                        status_reg    <= STAT_UNKNOWN;
                        state_reg     <= S_IDLE;
                    end
                end
                S_IMM_WAIT:
                begin
                    acc_reg    <= alu_result;
                    done_reg   <= 1'b1;
                    status_reg <= STAT_EXEC;
                    state_reg  <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy            = (state_reg != S_IDLE);
    assign done            = done_reg;
    assign status          = status_reg;
    assign program_counter = pc_reg;
    assign accumulator     = acc_reg;

    a_imm_finishes: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IMM_WAIT |=> done_reg && status_reg == STAT_EXEC)
        else $error("immediate instruction did not finish as executed");

    a_load_second_addr: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LOAD2 |-> mem_waddr == AW'($past(mem_waddr) + 1'b1))
        else $error("second load byte not written after the first");

    a_exec_running: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && status_reg == STAT_EXEC |-> run_state_reg == RUN_RUNNING)
        else $error("executed result while machine stopped");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy)
        else $error("result strobe while still busy");
endmodule

// ===== tb/acm_result_checker.sv =====
// Result checker for the accumulator machine: predicts every request and compares its result.
module acm_result_checker #(
    parameter int MEM_DEPTH = acm_pkg::MEM_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  logic       op,
    input  logic [7:0] address,
    input  logic [7:0] first_byte,
    input  logic [7:0] second_byte,
    input  logic       done,
    input  logic [2:0] status,
    input  logic [8:0] program_counter,
    input  logic [7:0] accumulator,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    output int         mismatches,
    output int         outstanding,
    output int         results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import acm_pkg::*;

    typedef struct packed {
        status_t    status;
        logic [8:0] pc;
        logic [7:0] acc;
    } machine_result_t;

    machine_result_t pending_results[$];

    logic [7:0] store_model [0:MEM_DEPTH-1];
    logic [7:0] acc_model;
    logic [8:0] pc_model;
    run_t       run_model;

    initial
    begin
        mismatches   = 0;
        outstanding  = 0;
        results_seen = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s: got 0x%0h, want 0x%0h (result %0d)",
                 what, got, want, results_seen);
        mismatches++;
    endtask

    // Execute one instruction on the model; stopped machines report their stop reason.
    task automatic run_instruction(output status_t st);
        logic [7:0] opc;
        logic [7:0] imm;
        logic [7:0] a;
        a  = acc_model;
        st = STAT_EXEC;
        if (run_model != RUN_RUNNING)
        begin
            st = status_t'({1'b0, run_model});
        end
        else if (pc_model >= MEM_DEPTH)
        begin
            run_model = RUN_PASTEND;
            st        = STAT_PASTEND;
        end
        else
        begin
            opc      = store_model[pc_model];
            pc_model = pc_model + 9'd1;
            if (opc == OPC_HALT)
            begin
                run_model = RUN_HALTED;
                st        = STAT_HALT;
            end
            else if (opc == OPC_ADD || opc == OPC_SUB || (opc >= OPC_LDI && opc <= OPC_XOR))
            begin
                // operand read at the end of the store stops the machine, pc stays at end
                if (pc_model >= MEM_DEPTH)
                begin
                    run_model = RUN_PASTEND;
                    st        = STAT_PASTEND;
                end
                else
                begin
                    imm      = store_model[pc_model];
                    pc_model = pc_model + 9'd1;
                    case (opc)
                        OPC_ADD: a = a + imm;
                        OPC_SUB: a = a - imm;
                        OPC_LDI: a = imm;
                        OPC_AND: a = a & imm;
                        OPC_OR:  a = a | imm;
                        default: a = a ^ imm;
                    endcase
                end
            end
            else
            begin
                case (opc)
                    OPC_NOT: a = ~a;
                    OPC_SHL: a = a << 1;
                    OPC_SHR: a = a >> 1;
                    OPC_INC: a = a + 8'd1;
                    OPC_DEC: a = a - 8'd1;
                    OPC_DBL: a = a + a;
                    OPC_HLV: a = a / 8'd2;
                    OPC_NOP: a = a & BYTE_ONES;
                    OPC_SET: a = a | BYTE_ONES;
                    default:
                    begin
                        run_model = RUN_UNKNOWN;
                        st        = STAT_UNKNOWN;
                    end
                endcase
            end
            if (st == STAT_EXEC)
                acc_model = a;
        end
    endtask

    task automatic predict_request(output machine_result_t res);
        status_t st;
        if (!op)
        begin
            if (address >= MEM_DEPTH - 1)
            begin
                st = STAT_BADLOAD;
            end
            else
            begin
                store_model[address]           = first_byte;
                store_model[int'(address) + 1] = second_byte;
                st = STAT_LOADED;
            end
        end
        else
        begin
            run_instruction(st);
        end
        res.status = st;
        res.pc     = pc_model;
        res.acc    = acc_model;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        machine_result_t want;
        machine_result_t fresh;
        if (!rst_n)
        begin
            for (int i = 0; i < MEM_DEPTH; i++)
                store_model[i] = '0;
            acc_model = '0;
            pc_model  = {1'b0, START_ADDR_RESET};
            run_model = RUN_RUNNING;
            pending_results.delete();
            outstanding <= 0;
        end
        else
        begin
            // compare against the oldest prediction before adding the new one
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch("result with no request pending", status, 0);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (status != want.status)
                        report_mismatch("status", status, want.status);
                    if (program_counter != want.pc)
                        report_mismatch("program_counter", program_counter, want.pc);
                    if (accumulator != want.acc)
                        report_mismatch("accumulator", accumulator, want.acc);
                end
                results_seen++;
            end
            if (cfg_wr_en)
                pc_model = {1'b0, cfg_wr_data};
            if (start && !busy)
            begin
                predict_request(fresh);
                pending_results.push_back(fresh);
            end
            outstanding <= pending_results.size();
        end
    end

endmodule

// ===== tb/tb_accumulator_machine_step.sv =====
// Testbench top for the accumulator machine: reset, request stimulus, watchdog and verdict.
module tb_accumulator_machine_step;
    timeunit 1ns;
    timeprecision 1ps;

    import acm_pkg::*;

    localparam int RANDOM_ITEMS = 1100;
    localparam int STALL_LIMIT  = 2000;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       start = 1'b0;
    logic       busy;
    logic       op = 1'b0;
    logic [7:0] address = '0;
    logic [7:0] first_byte = '0;
    logic [7:0] second_byte = '0;
    logic       done;
    logic [2:0] status;
    logic [8:0] program_counter;
    logic [7:0] accumulator;
    logic       cfg_wr_en = 1'b0;
    logic [7:0] cfg_wr_data = '0;

    int chk_mismatches;
    int chk_outstanding;
    int chk_results;

    logic [7:0] prog[$];
    int         exec_len;
    int         next_pc;
    int         n_requests = 0;
    int         n_cfg = 0;
    int         n_phases = 0;
    int         stall_cycles = 0;
    bit         quiet = 1'b0;
    string      stop_kind;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    accumulator_machine_step uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .op              (op),
        .address         (address),
        .first_byte      (first_byte),
        .second_byte     (second_byte),
        .done            (done),
        .status          (status),
        .program_counter (program_counter),
        .accumulator     (accumulator),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data)
    );

    acm_result_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .op              (op),
        .address         (address),
        .first_byte      (first_byte),
        .second_byte     (second_byte),
        .done            (done),
        .status          (status),
        .program_counter (program_counter),
        .accumulator     (accumulator),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .mismatches      (chk_mismatches),
        .outstanding     (chk_outstanding),
        .results_seen    (chk_results)
    );

    // End the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((start && !busy) || done || cfg_wr_en)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return BYTE_ONES;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_opcode();
        case ($urandom_range(0, 14))
            0:       return OPC_ADD;
            1:       return OPC_SUB;
            2:       return OPC_LDI;
            3:       return OPC_AND;
            4:       return OPC_OR;
            5:       return OPC_XOR;
            6:       return OPC_NOT;
            7:       return OPC_SHL;
            8:       return OPC_SHR;
            9:       return OPC_INC;
            10:      return OPC_DEC;
            11:      return OPC_DBL;
            12:      return OPC_HLV;
            13:      return OPC_NOP;
            default: return OPC_SET;
        endcase
    endfunction

    // Present one request and hold it until accepted; start stays high for a back-to-back one.
    task automatic send_item(input logic o, input logic [7:0] a, input logic [7:0] b1,
                             input logic [7:0] b2);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        op          <= o;
        address     <= a;
        first_byte  <= b1;
        second_byte <= b2;
        do @(posedge clk); while (busy);
        n_requests++;
    endtask

    task automatic step_machine();
        send_item(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // Drop start and hold until every predicted result has come back.
    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (chk_outstanding != 0);
    endtask

    task automatic set_start(input logic [7:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        n_cfg++;
    endtask

    task automatic load_program(input int base);
        for (int k = 0; k < prog.size(); k += 2)
            send_item(1'b0, 8'(base + k), prog[k], prog[k + 1]);
    endtask

    // Well-formed random program with no stopping opcode, padded to whole byte pairs.
    task automatic build_program(input int n);
        logic [7:0] opc;
        prog.delete();
        repeat (n)
        begin
            opc = pick_opcode();
            prog.push_back(opc);
            if (opc == OPC_ADD || opc == OPC_SUB || (opc >= OPC_LDI && opc <= OPC_XOR))
                prog.push_back(pick_byte());
        end
        exec_len = prog.size();
        if (prog.size() % 2 != 0)
            prog.push_back(pick_byte());
    endtask

    // Load that leaves the running program alone: a refused address or one outside it.
    task automatic noise_load(input int base, input int len);
        int a;
        a = 255;
        if ($urandom_range(0, 2) != 0)
        begin
            for (int tries = 0; tries < 8 && a == 255; tries++)
            begin
                a = $urandom_range(0, 254);
                if (!(a + 1 < base || a >= base + len))
                    a = 255;
            end
        end
        send_item(1'b0, 8'(a), pick_byte(), pick_byte());
    endtask

    task automatic run_phase(input int idx);
        int  n;
        int  base;
        bit  keep_pc;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 60) : $urandom_range(2, 20);
        build_program(n);
        quiet   = ($urandom_range(0, 3) == 0);
        keep_pc = (idx > 1) && ($urandom_range(0, 3) == 0) && (next_pc + prog.size() <= 255);
        if (keep_pc)
        begin
            // continue from where the last program ended, no register write
            base = next_pc;
        end
        else
        begin
            if (idx == 0)
                base = 0;
            else if (idx == 1)
                base = 255 - prog.size();
            else
                base = $urandom_range(0, 255 - prog.size());
            if (idx == 1)
                set_start(8'hFF);
            else if ($urandom_range(0, 7) == 0)
                set_start(8'($urandom));
            set_start(8'(base));
        end
        load_program(base);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 5) == 0)
                noise_load(base, prog.size());
            step_machine();
        end
        next_pc = base + exec_len;
        n_phases++;
    endtask

    initial
    begin
        int         base;
        int         idx;
        int         directed;
        logic [7:0] code;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every opcode but halt from the reset start address, with wrap on add and sub.
        prog = '{OPC_LDI, 8'hFF, OPC_ADD, 8'h01, OPC_SUB, 8'h01, OPC_AND, 8'h3C,
                 OPC_OR, 8'h81, OPC_XOR, 8'hFF, OPC_NOT, OPC_SHL, OPC_SHR, OPC_INC,
                 OPC_DEC, OPC_DBL, OPC_HLV, OPC_NOP, OPC_SET, OPC_NOP};
        exec_len = 21;
        load_program(START_ADDR_RESET);
        send_item(1'b0, 8'hFF, 8'h00, 8'hFF);
        send_item(1'b0, 8'hFE, 8'h00, 8'h00);
        for (int k = 0; k < 15; k++)
            send_item(1'b1, (k % 2) ? 8'hFF : 8'h00, 8'h00, 8'hFF);
        next_pc  = START_ADDR_RESET + exec_len;
        directed = n_requests;

        idx = 0;
        while (n_requests < directed + RANDOM_ITEMS)
        begin
            run_phase(idx);
            idx++;
        end

        // The machine can stop only once per run, so pick one way of stopping it.
        quiet = 1'b0;
        case ($urandom_range(0, 3))
            0:
            begin
                stop_kind = "halt";
                base = $urandom_range(0, 253);
                send_item(1'b0, 8'(base), OPC_INC, OPC_HALT);
                set_start(8'(base));
                repeat (3) step_machine();
            end
            1:
            begin
                stop_kind = "unknown opcode";
                do
                    code = 8'($urandom);
                while (code == OPC_HALT || code == OPC_ADD || code == OPC_SUB ||
                       (code >= OPC_LDI && code <= OPC_SET));
                base = $urandom_range(0, 253);
                send_item(1'b0, 8'(base), OPC_DEC, code);
                set_start(8'(base));
                repeat (3) step_machine();
            end
            2:
            begin
                stop_kind = "running off the end";
                send_item(1'b0, 8'hFE, OPC_INC, OPC_NOP);
                set_start(8'hFE);
                repeat (4) step_machine();
            end
            default:
            begin
                stop_kind = "operand read past the end";
                send_item(1'b0, 8'hFE, OPC_INC, OPC_XOR);
                set_start(8'hFE);
                repeat (3) step_machine();
            end
        endcase
        // loads still work while stopped; a new start address moves pc only
        send_item(1'b0, 8'($urandom_range(0, 254)), pick_byte(), pick_byte());
        send_item(1'b0, 8'hFF, pick_byte(), pick_byte());
        set_start(8'($urandom));
        repeat (2) step_machine();

        drain();
        repeat (10) @(posedge clk);
        $display("covered %0d requests in %0d program phases with %0d start-address writes",
                 n_requests, n_phases, n_cfg);
        $display("checked %0d results; machine finally stopped by %s", chk_results, stop_kind);
        if (chk_mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
